// ===== design/bsl_pkg.sv =====
package bsl_pkg;

  localparam int IMG_W      = 120;
  localparam int IMG_H      = 80;
  localparam int STORE_SIZE = IMG_W * IMG_H;
  localparam int ADDR_W     = 14;
  localparam int POS_W      = 7;
  localparam int COORD_W    = POS_W + 2;
  localparam int MAX_CANDS  = 128;
  localparam int CAND_AW    = 7;
  localparam int CNT_W      = 8;
  localparam int MIN_RUN    = 2;
  localparam int SHAPE_TOL  = 2;
  localparam int HALF_W     = IMG_W / 2;
  localparam int EDGE_FROM  = -60;
  localparam int EDGE_TO    = 60;
  localparam int BOX_W      = 14;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_CHECK,
    ST_PICK_RD,
    ST_PICK_EV,
    ST_FILTER,
    ST_BOX_INIT,
    ST_BOX_RD,
    ST_BOX_EV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIR_LEFT   = 2'd0,
    DIR_RIGHT  = 2'd1,
    DIR_TOP    = 2'd2,
    DIR_BOTTOM = 2'd3
  } dir_t;

  typedef struct packed {
    logic             valid;
    logic             has_cand;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pick_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic        [POS_W-1:0] y;
  } spot_t;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(IMG_W) + ADDR_W'(c);
  endfunction

endpackage

// ===== design/bsl_frame_store.sv =====
module bsl_frame_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bsl_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [bsl_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [bsl_pkg::STORE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bsl_filter.sv =====
module bsl_filter (
  input  logic           clk,
  input  logic           rst,
  input  bsl_pkg::pick_t pick,
  output bsl_pkg::spot_t spot
);

  typedef logic signed [7:0] val_t;

  val_t hist_x [2];
  val_t hist_y [2];
  val_t bx, by, fx, fy, fx_fix;

  function automatic val_t median3(input val_t a, input val_t b, input val_t c);
    val_t lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  always_comb begin
    bx = pick.has_cand ? val_t'({1'b0, pick.x}) - 8'sd60 : -8'sd60;
    by = pick.has_cand ? val_t'({1'b0, pick.y}) : 8'sd0;
    if (bx < -8'(bsl_pkg::HALF_W)) begin
      bx = -8'(bsl_pkg::HALF_W);
    end else if (bx > 8'(bsl_pkg::HALF_W)) begin
      bx = 8'(bsl_pkg::HALF_W);
    end
    if (by > 8'(bsl_pkg::IMG_H)) begin
      by = 8'(bsl_pkg::IMG_H);
    end
    fx = median3(hist_x[0], hist_x[1], bx);
    fy = median3(hist_y[0], hist_y[1], by);
    fx_fix = fx;
    // pull a dead-left reading with no row back to the origin
    if (fx_fix == -8'(bsl_pkg::HALF_W) && fy == 8'sd0) begin
      fx_fix = 8'sd0;
    end
    if (fx_fix == 8'(bsl_pkg::EDGE_FROM)) begin
      fx_fix = 8'(bsl_pkg::EDGE_TO);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_x[0] <= '0;
      hist_x[1] <= '0;
      hist_y[0] <= '0;
      hist_y[1] <= '0;
    end else if (pick.valid) begin
      hist_x[0] <= hist_x[1];
      hist_x[1] <= bx;
      hist_y[0] <= hist_y[1];
      hist_y[1] <= by;
    end
  end

  always_ff @(posedge clk) begin
    if (pick.valid) begin
      spot.x <= fx_fix[bsl_pkg::POS_W-1:0];
      spot.y <= fy[bsl_pkg::POS_W-1:0];
    end
  end

endmodule

// ===== design/bsl_scan.sv =====
module bsl_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [7:0]                 thr,
  output logic [bsl_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output bsl_pkg::pick_t             pick,
  input  bsl_pkg::spot_t             spot,
  output logic                       busy,
  output logic                       done,
  output logic [bsl_pkg::BOX_W-1:0]  box_n
);

  localparam int PW = bsl_pkg::POS_W;
  localparam int CW = bsl_pkg::COORD_W;
  localparam int CAND_IDX_W = bsl_pkg::CAND_AW;

  bsl_pkg::state_t state, state_next;

  logic [PW-1:0] row, col, run, wx, wy;
  logic [PW-1:0] ext [4];
  logic [1:0]    dir;
  logic [bsl_pkg::CNT_W-1:0] cand_count;
  logic [2*PW-1:0] cand_mem [bsl_pkg::MAX_CANDS];
  logic [2*PW-1:0] cand_rd;
  bsl_pkg::coord_t br, bc, r0, r1, c1;

  logic lit, last_col, last_px, run_ends;
  bsl_pkg::coord_t walk_r, walk_c, c0_calc, c1_calc, r0_calc, r1_calc;
  logic walk_in, box_in, box_last, found, box_empty, shape_ok;
  logic [PW:0] dlr, dtb;

  always_comb begin
    lit      = rd_data > thr;
    last_col = col == PW'(bsl_pkg::IMG_W - 1);
    last_px  = last_col && row == PW'(bsl_pkg::IMG_H - 1);
    run_ends = !lit && run >= PW'(bsl_pkg::MIN_RUN);

    walk_r = CW'(wy);
    walk_c = CW'(wx);
    unique case (bsl_pkg::dir_t'(dir))
      bsl_pkg::DIR_LEFT:   walk_c = CW'(wx) - CW'(ext[0]);
      bsl_pkg::DIR_RIGHT:  walk_c = CW'(wx) + CW'(ext[1]);
      bsl_pkg::DIR_TOP:    walk_r = CW'(wy) - CW'(ext[2]);
      bsl_pkg::DIR_BOTTOM: walk_r = CW'(wy) + CW'(ext[3]);
      default:             walk_r = CW'(wy);
    endcase
    walk_in = walk_r >= 0 && walk_r < CW'(bsl_pkg::IMG_H)
           && walk_c >= 0 && walk_c < CW'(bsl_pkg::IMG_W);
    box_in  = br >= 0 && br < CW'(bsl_pkg::IMG_H)
           && bc >= 0 && bc < CW'(bsl_pkg::IMG_W);
    box_last = (br + CW'(1) >= r1) && (bc + CW'(1) >= c1);

    dlr = (ext[0] > ext[1]) ? {1'b0, ext[0]} - {1'b0, ext[1]}
                            : {1'b0, ext[1]} - {1'b0, ext[0]};
    dtb = (ext[2] > ext[3]) ? {1'b0, ext[2]} - {1'b0, ext[3]}
                            : {1'b0, ext[3]} - {1'b0, ext[2]};
    shape_ok = dlr <= (PW+1)'(bsl_pkg::SHAPE_TOL) && dtb <= (PW+1)'(bsl_pkg::SHAPE_TOL)
            && ext[0] != '0 && cand_count < bsl_pkg::CNT_W'(bsl_pkg::MAX_CANDS);

    found   = spot.x != '0 || spot.y != '0;
    c0_calc = CW'(spot.x) + CW'(bsl_pkg::HALF_W) - CW'(ext[0]);
    c1_calc = CW'(spot.x) + CW'(bsl_pkg::HALF_W) + CW'(ext[1]);
    r0_calc = CW'({1'b0, spot.y}) - CW'(ext[2]);
    r1_calc = CW'({1'b0, spot.y}) + CW'(ext[3]);
    box_empty = c0_calc >= c1_calc || r0_calc >= r1_calc;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bsl_pkg::ST_IDLE:    if (start) state_next = bsl_pkg::ST_SCAN_RD;
      bsl_pkg::ST_SCAN_RD: state_next = bsl_pkg::ST_SCAN_EV;
      bsl_pkg::ST_SCAN_EV: begin
        if (run_ends) state_next = bsl_pkg::ST_WALK_RD;
        else if (last_px) state_next = bsl_pkg::ST_PICK_RD;
        else state_next = bsl_pkg::ST_SCAN_RD;
      end
      bsl_pkg::ST_WALK_RD: begin
        if (walk_in) state_next = bsl_pkg::ST_WALK_EV;
        else if (dir == 2'(bsl_pkg::DIR_BOTTOM)) state_next = bsl_pkg::ST_CHECK;
      end
      bsl_pkg::ST_WALK_EV: begin
        if (rd_data != '0 || dir != 2'(bsl_pkg::DIR_BOTTOM)) begin
          state_next = bsl_pkg::ST_WALK_RD;
        end else begin
          state_next = bsl_pkg::ST_CHECK;
        end
      end
      bsl_pkg::ST_CHECK:
        state_next = last_px ? bsl_pkg::ST_PICK_RD : bsl_pkg::ST_SCAN_RD;
      bsl_pkg::ST_PICK_RD: state_next = bsl_pkg::ST_PICK_EV;
      bsl_pkg::ST_PICK_EV: state_next = bsl_pkg::ST_FILTER;
      bsl_pkg::ST_FILTER:  state_next = bsl_pkg::ST_BOX_INIT;
      bsl_pkg::ST_BOX_INIT:
        state_next = (!found || box_empty) ? bsl_pkg::ST_DONE : bsl_pkg::ST_BOX_RD;
      bsl_pkg::ST_BOX_RD: begin
        if (box_in) state_next = bsl_pkg::ST_BOX_EV;
        else if (box_last) state_next = bsl_pkg::ST_DONE;
      end
      bsl_pkg::ST_BOX_EV:
        state_next = box_last ? bsl_pkg::ST_DONE : bsl_pkg::ST_BOX_RD;
      bsl_pkg::ST_DONE: state_next = bsl_pkg::ST_IDLE;
      default: state_next = bsl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr       = '0;
    pick.valid    = 1'b0;
    pick.has_cand = cand_count != '0;
    pick.x        = cand_rd[2*PW-1:PW];
    pick.y        = cand_rd[PW-1:0];
    busy          = state != bsl_pkg::ST_IDLE;
    done          = 1'b0;
    unique case (state)
      bsl_pkg::ST_SCAN_RD: rd_addr = bsl_pkg::frame_addr(row, col);
      bsl_pkg::ST_WALK_RD: rd_addr = bsl_pkg::frame_addr(walk_r[PW-1:0], walk_c[PW-1:0]);
      bsl_pkg::ST_BOX_RD:  rd_addr = bsl_pkg::frame_addr(br[PW-1:0], bc[PW-1:0]);
      bsl_pkg::ST_PICK_EV: pick.valid = 1'b1;
      bsl_pkg::ST_DONE:    done = 1'b1;
      default:             rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // candidate list
  always_ff @(posedge clk) begin
    if (state == bsl_pkg::ST_CHECK && shape_ok) begin
      cand_mem[cand_count[CAND_IDX_W-1:0]] <= {wx, wy};
    end
    cand_rd <= cand_mem[cand_count[bsl_pkg::CNT_W-1:1]];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bsl_pkg::ST_IDLE: begin
        row        <= '0;
        col        <= '0;
        run        <= '0;
        cand_count <= '0;
        for (int i = 0; i < 4; i++) ext[i] <= '0;
      end
      bsl_pkg::ST_SCAN_EV: begin
        if (run_ends) begin
          wx  <= col - (run >> 1);
          wy  <= row;
          dir <= '0;
          for (int i = 0; i < 4; i++) ext[i] <= '0;
          run <= '0;
        end else begin
          run <= lit ? run + 1'b1 : '0;
          if (last_col) begin
            col <= '0;
            row <= row + 1'b1;
            run <= '0;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
      bsl_pkg::ST_WALK_RD: begin
        if (!walk_in) dir <= dir + 1'b1;
      end
      bsl_pkg::ST_WALK_EV: begin
        if (rd_data != '0) ext[dir] <= ext[dir] + 1'b1;
        else dir <= dir + 1'b1;
      end
      bsl_pkg::ST_CHECK: begin
        if (shape_ok) cand_count <= cand_count + 1'b1;
        if (last_col) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      bsl_pkg::ST_BOX_INIT: begin
        box_n <= '0;
        br    <= r0_calc;
        bc    <= c0_calc;
        r0    <= r0_calc;
        r1    <= r1_calc;
        c1    <= c1_calc;
      end
      bsl_pkg::ST_BOX_RD: begin
        if (!box_in) begin
          if (br + CW'(1) >= r1) begin
            br <= r0;
            bc <= bc + CW'(1);
          end else begin
            br <= br + CW'(1);
          end
        end
      end
      bsl_pkg::ST_BOX_EV: begin
        if (rd_data != '0) box_n <= box_n + 1'b1;
        if (br + CW'(1) >= r1) begin
          br <= r0;
          bc <= bc + CW'(1);
        end else begin
          br <= br + CW'(1);
        end
      end
      default: begin
        dir <= dir;
      end
    endcase
  end

endmodule

// ===== design/bright_spot_locator.sv =====
// Bright spot locator. Pixels of one frame stream in on the input channel
// in raster order, one beat per pixel, and land in a 120x80 frame store at
// one beat per cycle while no search runs. The beat flagged with frame_end
// starts the search: the block then stops taking pixels while one sequencer
// walks the frame store through its single read port. It scans every pixel
// once, walks the four arms of every lit run of at least two pixels that
// ends in a dark pixel (one read per arm pixel), picks the middle round
// candidate, median-filters it over the last three frames and finally
// counts the nonzero pixels in the spot's box. One result beat per frame
// follows. Pixels of the next frame are taken while that result waits, but
// its frame_end beat is held until the result has gone out. Pixels past
// 9600 in a frame are dropped.
module bright_spot_locator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        pixel_value,
  input  logic                              frame_end,
  input  logic                              threshold_we,
  input  logic [7:0]                        threshold_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bsl_pkg::POS_W-1:0]  spot_x,
  output logic [bsl_pkg::POS_W-1:0]         spot_y,
  output logic                              spot_found,
  output logic [bsl_pkg::BOX_W-1:0]         box_pixel_count
);

  logic [7:0]                 pixel_threshold;
  logic [bsl_pkg::ADDR_W-1:0] pixel_addr;
  logic [bsl_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 rd_data;
  logic                       in_accept, store_we, busy, done;
  logic [bsl_pkg::BOX_W-1:0]  box_n;
  bsl_pkg::pick_t             pick;
  bsl_pkg::spot_t             spot;

  // hold the frame-end beat while the previous result is still pending
  assign in_stall  = busy || (out_valid && frame_end);
  assign in_accept = in_valid && !in_stall;
  assign store_we  = in_accept && pixel_addr < bsl_pkg::ADDR_W'(bsl_pkg::STORE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_threshold <= 8'd128;
    end else if (threshold_we) begin
      pixel_threshold <= threshold_data;
    end
  end

  // write pointer: advance per stored pixel, rewind on frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_addr <= '0;
    end else if (in_accept) begin
      if (frame_end) begin
        pixel_addr <= '0;
      end else if (store_we) begin
        pixel_addr <= pixel_addr + 1'b1;
      end
    end
  end

  bsl_frame_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (pixel_addr),
    .wdata (pixel_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bsl_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (in_accept && frame_end),
    .thr     (pixel_threshold),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .pick    (pick),
    .spot    (spot),
    .busy    (busy),
    .done    (done),
    .box_n   (box_n)
  );

  bsl_filter u_filter (
    .clk  (clk),
    .rst  (rst),
    .pick (pick),
    .spot (spot)
  );

  // result register: load on search done, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      spot_x          <= spot.x;
      spot_y          <= spot.y;
      spot_found      <= spot.x != '0 || spot.y != '0;
      box_pixel_count <= (spot.x != '0 || spot.y != '0) ? box_n : '0;
    end
  end

endmodule

// ===== test/bsl_checker.sv =====
module bsl_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [7:0]                        pixel_value,
  input  logic                              frame_end,
  input  logic                              threshold_we,
  input  logic [7:0]                        threshold_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [bsl_pkg::POS_W-1:0]  spot_x,
  input  logic [bsl_pkg::POS_W-1:0]         spot_y,
  input  logic                              spot_found,
  input  logic [bsl_pkg::BOX_W-1:0]         box_pixel_count,
  output int                                errors,
  output int                                pending,
  output int                                spots_seen
);
  import bsl_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic [POS_W-1:0]        y;
    logic                    found;
    logic [BOX_W-1:0]        cnt;
  } spot_rec_t;

  logic [7:0] store [STORE_SIZE];
  logic [7:0] thr;
  int         wr_addr;
  int         past_x [2];
  int         past_y [2];
  int         arm [4];
  int         cand_x [$];
  int         cand_y [$];
  spot_rec_t  spot_q [$];

  initial begin
    foreach (store[i]) store[i] = '0;
    errors = 0;
    spots_seen = 0;
  end

  assign pending = spot_q.size();

  function automatic int lum(int r, int c);
    if (r < 0 || r >= IMG_H || c < 0 || c >= IMG_W) return 0;
    return store[r*IMG_W + c];
  endfunction

  function automatic int med3(int a, int b, int c);
    int lo, hi, m;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    m  = hi < c ? hi : c;
    return lo > m ? lo : m;
  endfunction

  function automatic int adiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  // Measure the four arms of a run midpoint; keep it if near round.
  task automatic measure_arms(int x, int y);
    int l, rt, t, b;
    l = 0; rt = 0; t = 0; b = 0;
    while (x - l >= 0 && lum(y, x - l) != 0) l++;
    while (x + rt < IMG_W && lum(y, x + rt) != 0) rt++;
    while (y - t >= 0 && lum(y - t, x) != 0) t++;
    while (y + b < IMG_H && lum(y + b, x) != 0) b++;
    arm[DIR_LEFT] = l; arm[DIR_RIGHT] = rt; arm[DIR_TOP] = t; arm[DIR_BOTTOM] = b;
    if (adiff(l, rt) <= SHAPE_TOL && adiff(t, b) <= SHAPE_TOL && l > 0 &&
        cand_x.size() < MAX_CANDS) begin
      cand_x.push_back(x);
      cand_y.push_back(y);
    end
  endtask

  task automatic locate_spot();
    int run, bx, by, fx, fy, n;
    spot_rec_t s;
    cand_x.delete();
    cand_y.delete();
    foreach (arm[i]) arm[i] = 0;
    for (int r = 0; r < IMG_H; r++) begin
      run = 0;
      for (int c = 0; c < IMG_W; c++) begin
        if (lum(r, c) > thr) run++;
        else begin
          if (run >= MIN_RUN) measure_arms(c - run / 2, r);
          run = 0;
        end
      end
    end
    bx = 0; by = 0;
    if (cand_x.size() > 0) begin
      bx = cand_x[cand_x.size() >> 1];
      by = cand_y[cand_y.size() >> 1];
    end
    bx = bx - HALF_W;
    if (bx < -HALF_W) bx = -HALF_W;
    if (bx > HALF_W) bx = HALF_W;
    if (by > IMG_H) by = IMG_H;
    fx = med3(past_x[0], past_x[1], bx);
    fy = med3(past_y[0], past_y[1], by);
    past_x[0] = past_x[1]; past_x[1] = bx;
    past_y[0] = past_y[1]; past_y[1] = by;
    // Left edge fix-ups.
    if (fx == -HALF_W && fy == 0) fx = 0;
    if (fx == EDGE_FROM) fx = EDGE_TO;
    n = 0;
    if (fx != 0 || fy != 0) begin
      for (int c = fx + HALF_W - arm[DIR_LEFT]; c < fx + HALF_W + arm[DIR_RIGHT]; c++)
        for (int r = fy - arm[DIR_TOP]; r < fy + arm[DIR_BOTTOM]; r++)
          if (lum(r, c) != 0) n++;
    end
    s.x = POS_W'(fx);
    s.y = POS_W'(fy);
    s.found = (fx != 0 || fy != 0);
    s.cnt = BOX_W'(n);
    spot_q.push_back(s);
  endtask

  always @(posedge clk) begin
    spot_rec_t e;
    if (rst) begin
      thr = 8'd128;
      wr_addr = 0;
      past_x = '{0, 0};
      past_y = '{0, 0};
      spot_q.delete();
    end else begin
      if (threshold_we) thr = threshold_data;
      if (out_valid && !out_stall) begin
        spots_seen++;
        if (spot_q.size() == 0) begin
          $error("result beat with no spot expected");
          errors++;
        end else begin
          e = spot_q.pop_front();
          if (spot_x !== e.x) begin
            $error("spot_x: expected %0d, got %0d", e.x, spot_x); errors++;
          end
          if (spot_y !== e.y) begin
            $error("spot_y: expected %0d, got %0d", e.y, spot_y); errors++;
          end
          if (spot_found !== e.found) begin
            $error("spot_found: expected %0b, got %0b", e.found, spot_found); errors++;
          end
          if (box_pixel_count !== e.cnt) begin
            $error("box_pixel_count: expected %0d, got %0d", e.cnt, box_pixel_count);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (wr_addr < STORE_SIZE) begin
          store[wr_addr] = pixel_value;
          wr_addr++;
        end
        if (frame_end) begin
          wr_addr = 0;
          locate_spot();
        end
      end
    end
  end

endmodule

// ===== test/tb_bright_spot_locator.sv =====
module tb_bright_spot_locator;
  import bsl_pkg::*;

  localparam int STALL_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pixel_value = '0;
  logic        frame_end = 1'b0;
  logic        threshold_we = 1'b0;
  logic [7:0]  threshold_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [POS_W-1:0] spot_x;
  logic [POS_W-1:0]        spot_y;
  logic                    spot_found;
  logic [BOX_W-1:0]        box_pixel_count;

  int errors, pending, spots_seen;
  int idle_pct, stall_pct;
  int quiet_cycles;
  int pixels_sent, frames_sent;
  logic [7:0] cur_thr;

  // Blob description for the frame under construction.
  int nblobs;
  int blob_c [3];
  int blob_r [3];
  int blob_rad [3];
  int noise_pct;

  always #4 clk = ~clk;

  bright_spot_locator i_dut (
    .clk, .rst, .in_valid, .in_stall, .pixel_value, .frame_end,
    .threshold_we, .threshold_data, .out_valid, .out_stall,
    .spot_x, .spot_y, .spot_found, .box_pixel_count
  );

  bsl_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .pixel_value, .frame_end,
    .threshold_we, .threshold_data, .out_valid, .out_stall,
    .spot_x, .spot_y, .spot_found, .box_pixel_count,
    .errors, .pending, .spots_seen
  );

  // Receiver: stall at random with the phase's rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Send one pixel beat; hold it until the block takes it.
  task automatic send_pixel(logic [7:0] v, logic last);
    logic st;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      pixel_value <= 8'($urandom);
      frame_end <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= v;
    frame_end <= last;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    pixels_sent++;
  endtask

  // Lit level for a blob pixel: mostly above the threshold, sometimes not.
  function automatic logic [7:0] lit_level();
    if ($urandom_range(9) == 0) return 8'($urandom);
    if (cur_thr == 8'hff) return 8'hff;
    return 8'($urandom_range(255, cur_thr + 1));
  endfunction

  function automatic logic [7:0] frame_pixel(int a);
    int r, c, dr, dc;
    r = a / IMG_W;
    c = a % IMG_W;
    for (int b = 0; b < nblobs; b++) begin
      dr = r - blob_r[b];
      dc = c - blob_c[b];
      if (dr*dr + dc*dc <= blob_rad[b]*blob_rad[b]) return lit_level();
    end
    if ($urandom_range(99) < noise_pct) return 8'($urandom);
    return 8'h00;
  endfunction

  task automatic send_frame(int len);
    for (int a = 0; a < len; a++) send_pixel(frame_pixel(a), a == len - 1);
    frames_sent++;
  endtask

  // Random blobs confined to the rows that a frame of len pixels rewrites.
  task automatic pick_blobs(int len);
    int rows;
    rows = (len + IMG_W - 1) / IMG_W;
    if (rows > IMG_H) rows = IMG_H;
    nblobs = $urandom_range(3);
    for (int b = 0; b < nblobs; b++) begin
      blob_r[b] = $urandom_range(rows - 1);
      blob_c[b] = $urandom_range(IMG_W - 1);
      blob_rad[b] = $urandom_range(6);
    end
    noise_pct = ($urandom_range(3) == 0) ? $urandom_range(8) : 0;
  endtask

  task automatic write_threshold(logic [7:0] v);
    threshold_we <= 1'b1;
    threshold_data <= v;
    cur_thr = v;
    @(posedge clk);
    threshold_we <= 1'b0;
  endtask

  // Wait until every spot has come out, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int ip, int sp, logic [7:0] thr, int nframes);
    int len;
    idle_pct = ip;
    stall_pct = sp;
    write_threshold(thr);
    for (int f = 0; f < nframes; f++) begin
      case ($urandom_range(19))
        0:       len = STORE_SIZE;
        1:       len = STORE_SIZE + $urandom_range(1, 12);
        default: len = $urandom_range(1, 1200);
      endcase
      pick_blobs(len);
      send_frame(len);
    end
    drain();
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    pixels_sent = 0;
    frames_sent = 0;
    cur_thr = 8'd128;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the first frame fills the whole store so that every later
    // search reads written pixels. One round spot plus one at the right edge.
    write_threshold(8'd128);
    nblobs = 2; noise_pct = 0;
    blob_r = '{40, 20, 0}; blob_c = '{60, 118, 0}; blob_rad = '{4, 3, 0};
    send_frame(STORE_SIZE);
    // Two dark frames: no candidate, exercise the left edge fix-ups.
    nblobs = 0;
    send_frame(STORE_SIZE);
    send_frame(STORE_SIZE);
    // Overlong frame with spots at the left edge and near the corner.
    nblobs = 3;
    blob_r = '{10, 79, 50}; blob_c = '{1, 119, 3}; blob_rad = '{2, 3, 1};
    send_frame(STORE_SIZE + 7);
    // Short frames: a one-pixel frame and a frame of one bright row.
    nblobs = 0;
    send_frame(1);
    nblobs = 1; blob_r = '{0, 0, 0}; blob_c = '{60, 0, 0}; blob_rad = '{0, 0, 0};
    for (int a = 0; a < IMG_W; a++) send_pixel(8'hff, a == IMG_W - 1);
    frames_sent++;
    drain();

    // Random phases across idling patterns and threshold settings.
    random_phase(0, 0, 8'd0, 10);
    random_phase(68, 0, 8'd255, 5);
    random_phase(0, 68, 8'($urandom), 10);
    random_phase(28, 28, 8'($urandom), 10);
    random_phase(0, 0, 8'($urandom_range(1, 254)), 10);
    repeat (50) @(posedge clk);

    $display("Sent %0d frames (%0d pixel beats), checked %0d spot results",
             frames_sent, pixels_sent, spots_seen);
    $display("over thresholds 0, 255 and random, with sender gaps and receiver stalls.");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
